@@ sv/png_scanline_unfilter_to_argb_core_assert.svh @@
// ---------------------------------------------------------------------------
// png scanline unfilter assertion macros
// shared property forms for the unfilter datapath; every user has clk and
// arst_n in scope
// ---------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_TO_ARGB_CORE_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_TO_ARGB_CORE_ASSERT_SVH

// consequent must hold on the same edge as the antecedent
`define PNGU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold on the edge after the antecedent
`define PNGU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/pngu_pkg.sv @@
// ---------------------------------------------------------------------------
// pngu_pkg
// shared codes, configuration and stage word types of the png unfilter core
// ---------------------------------------------------------------------------
package pngu_pkg;

	// input word commands
	localparam logic CMD_STREAM  = 1'b0;
	localparam logic CMD_PALETTE = 1'b1;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_VALID = 2'd2;

	// colour types
	localparam logic [2:0] FMT_GRAY       = 3'd0;
	localparam logic [2:0] FMT_RGB        = 3'd2;
	localparam logic [2:0] FMT_INDEXED    = 3'd3;
	localparam logic [2:0] FMT_GRAY_ALPHA = 3'd4;
	localparam logic [2:0] FMT_RGBA       = 3'd6;

	// row filter types
	localparam logic [7:0] FILT_SUB     = 8'd1;
	localparam logic [7:0] FILT_UP      = 8'd2;
	localparam logic [7:0] FILT_AVERAGE = 8'd3;
	localparam logic [7:0] FILT_PAETH   = 8'd4;

	localparam logic [31:0] ARGB_OPAQUE = 32'hFF00_0000;

	typedef struct packed {
		logic [12:0] image_width;
		logic [2:0]  pixel_format;
		logic        palette_valid;
	} cfg_t;

	typedef enum logic {
		ITEM_ROW_START,
		ITEM_SAMPLE
	} item_kind_t;

	// stream word handed from row control to reconstruction
	typedef struct packed {
		item_kind_t kind;
		logic [7:0] filter;
		logic [7:0] sample;
		logic       upper_ok;
		logic       store_ok;
		logic       pixel_done;
		logic       row_end;
	} smp_t;

	// bytes per pixel minus one
	function automatic logic [1:0] bpp_m1(input logic [2:0] fmt);
		logic [1:0] m;
		unique case (fmt)
			FMT_RGB:        m = 2'd2;
			FMT_GRAY_ALPHA: m = 2'd1;
			FMT_RGBA:       m = 2'd3;
			default:        m = 2'd0;
		endcase
		return m;
	endfunction

endpackage

@@ sv/pngu_row_ctrl.sv @@
// ---------------------------------------------------------------------------
// pngu_row_ctrl
// row bookkeeping at word acceptance: filter byte, position in the row,
// pixel phase and row end; issues the upper row address for prefetch
// ---------------------------------------------------------------------------
module pngu_row_ctrl #(
	parameter int MAX_WIDTH = 4096,
	parameter int ROW_BYTES = 16384,
	localparam int POS_W  = $clog2(MAX_WIDTH * 4),
	localparam int LEN_W  = POS_W + 1,
	localparam int ADDR_W = $clog2(ROW_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pngu_pkg::cfg_t      cfg,
	input  logic                img_fire,
	input  logic [7:0]          image_byte,
	input  logic                image_start,
	output pngu_pkg::smp_t      smp,
	output logic [ADDR_W-1:0]   rd_addr
);

	logic              awaiting_q;
	logic              first_row_q;
	logic [7:0]        filter_q;
	logic [POS_W-1:0]  pos_q;
	logic [1:0]        mod3_q;

	logic              awaiting;
	logic              pixel_done;
	logic              last;
	logic              row_fit;
	logic [1:0]        bm1;
	logic [31:0]       width32;
	logic [LEN_W-1:0]  width_eff;
	logic [LEN_W-1:0]  row_len;
	logic [LEN_W-1:0]  pos_inc;

	// row length from the clamped width
	always_comb begin
		bm1     = pngu_pkg::bpp_m1(cfg.pixel_format);
		width32 = 32'(cfg.image_width);
		if (width32 == 32'd0) begin
			width32 = 32'd1;
		end else if (width32 > 32'(MAX_WIDTH)) begin
			width32 = 32'(MAX_WIDTH);
		end
		width_eff = LEN_W'(width32);
		unique case (bm1)
			2'd0: row_len = width_eff;
			2'd1: row_len = width_eff << 1;
			2'd2: row_len = (width_eff << 1) + width_eff;
			2'd3: row_len = width_eff << 2;
		endcase
	end

	// position, pixel phase and row end
	always_comb begin
		awaiting = awaiting_q || image_start;
		pos_inc  = LEN_W'(pos_q) + LEN_W'(1);
		last     = pos_inc >= row_len;
		row_fit  = 32'(pos_q) < 32'(ROW_BYTES);
		unique case (bm1)
			2'd0: pixel_done = 1'b1;
			2'd1: pixel_done = pos_q[0];
			2'd2: pixel_done = (mod3_q == 2'd2);
			2'd3: pixel_done = &pos_q[1:0];
		endcase
	end

	// word for the reconstruction stage
	always_comb begin
		smp = '0;
		if (awaiting) begin
			smp.kind = pngu_pkg::ITEM_ROW_START;
		end else begin
			smp.kind       = pngu_pkg::ITEM_SAMPLE;
			smp.filter     = filter_q;
			smp.sample     = image_byte;
			smp.upper_ok   = !first_row_q && row_fit;
			smp.store_ok   = row_fit;
			smp.pixel_done = pixel_done;
			smp.row_end    = last;
		end
		rd_addr = ADDR_W'(pos_q);
	end

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b1;
			first_row_q <= 1'b1;
			filter_q    <= 8'd0;
			pos_q       <= '0;
			mod3_q      <= 2'd0;
		end else if (img_fire) begin
			if (awaiting) begin
				filter_q   <= image_byte;
				awaiting_q <= 1'b0;
				pos_q      <= '0;
				mod3_q     <= 2'd0;
				if (image_start) begin
					first_row_q <= 1'b1;
				end
			end else if (last) begin
				awaiting_q  <= 1'b1;
				first_row_q <= 1'b0;
				pos_q       <= '0;
				mod3_q      <= 2'd0;
			end else begin
				pos_q  <= pos_inc[POS_W-1:0];
				mod3_q <= (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
			end
		end
	end

endmodule

@@ sv/pngu_recon.sv @@
// ---------------------------------------------------------------------------
// pngu_recon
// reconstruction stage: line memory read at acceptance, filter prediction,
// write-back of the rebuilt byte and pixel assembly
// ---------------------------------------------------------------------------
`include "png_scanline_unfilter_to_argb_core_assert.svh"

module pngu_recon #(
	parameter int ROW_BYTES = 16384,
	localparam int ADDR_W = $clog2(ROW_BYTES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pngu_pkg::cfg_t     cfg,
	input  logic               in_load,
	input  pngu_pkg::smp_t     smp,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic               s1_free,
	output logic               pix_valid,
	input  logic               pix_ready,
	output logic [31:0]        px,
	output logic               pix_row_end
);

	logic               s1_valid_q;
	pngu_pkg::smp_t     smp_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [7:0]         upper_s1;
	logic [31:0]        left_q;
	logic [31:0]        upper_q;
	logic [23:0]        asm_q;

	logic [1:0]         bm1;
	logic [7:0]         a;
	logic [7:0]         b;
	logic [7:0]         c;
	logic [8:0]         avg_sum;
	logic [7:0]         pred;
	logic [7:0]         rec;
	logic [31:0]        px_c;
	logic               is_sample;
	logic               s1_go;
	logic               rd_en;
	logic               wr_en;

	logic [7:0]         line_mem [ROW_BYTES];

	// paeth predictor
	function automatic logic [7:0] paeth(input logic [7:0] x, input logic [7:0] y,
		input logic [7:0] z);
		logic [7:0] pa;
		logic [7:0] pb;
		logic [9:0] sxy;
		logic [9:0] szz;
		logic [9:0] pc;
		logic [7:0] r;
		pa  = (y > z) ? y - z : z - y;
		pb  = (x > z) ? x - z : z - x;
		sxy = 10'(x) + 10'(y);
		szz = {1'b0, z, 1'b0};
		pc  = (sxy > szz) ? sxy - szz : szz - sxy;
		if ((pa <= pb) && (10'(pa) <= pc)) begin
			r = x;
		end else if (10'(pb) <= pc) begin
			r = y;
		end else begin
			r = z;
		end
		return r;
	endfunction

	// prediction and rebuilt byte
	always_comb begin
		bm1     = pngu_pkg::bpp_m1(cfg.pixel_format);
		a       = left_q[{bm1, 3'b000} +: 8];
		c       = upper_q[{bm1, 3'b000} +: 8];
		b       = smp_s1.upper_ok ? upper_s1 : 8'd0;
		avg_sum = {1'b0, a} + {1'b0, b};
		unique case (smp_s1.filter)
			pngu_pkg::FILT_SUB:     pred = a;
			pngu_pkg::FILT_UP:      pred = b;
			pngu_pkg::FILT_AVERAGE: pred = avg_sum[8:1];
			pngu_pkg::FILT_PAETH:   pred = paeth(a, b, c);
			default:                pred = 8'd0;
		endcase
		rec  = smp_s1.sample + pred;
		px_c = {asm_q, rec};
	end

	// stage handshake and memory enables
	always_comb begin
		is_sample   = (smp_s1.kind == pngu_pkg::ITEM_SAMPLE);
		pix_valid   = s1_valid_q && is_sample && smp_s1.pixel_done;
		s1_go       = s1_valid_q && (!pix_valid || pix_ready);
		s1_free     = !s1_valid_q || s1_go;
		rd_en       = in_load && (smp.kind == pngu_pkg::ITEM_SAMPLE) && smp.store_ok;
		wr_en       = s1_go && is_sample && smp_s1.store_ok;
		px          = px_c;
		pix_row_end = smp_s1.row_end;
	end

	// line memory: upper byte prefetch at acceptance, write-back on leaving
	always_ff @(posedge clk) begin
		if (rd_en) begin
			upper_s1 <= line_mem[rd_addr];
		end
		if (wr_en) begin
			line_mem[addr_s1] <= rec;
		end
	end

	// stage word
	always_ff @(posedge clk) begin
		if (in_load) begin
			smp_s1  <= smp;
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_load) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	// left, upper-left and partial pixel history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= 32'd0;
			upper_q <= 32'd0;
			asm_q   <= 24'd0;
		end else if (s1_go) begin
			if (!is_sample) begin
				left_q  <= 32'd0;
				upper_q <= 32'd0;
				asm_q   <= 24'd0;
			end else begin
				left_q  <= {left_q[23:0], rec};
				upper_q <= {upper_q[23:0], b};
				if (smp_s1.pixel_done || smp_s1.row_end) begin
					asm_q <= 24'd0;
				end else begin
					asm_q <= px_c[23:0];
				end
			end
		end
	end

	`PNGU_ASSERT_IMP(a_line_mem_no_collide, rd_en && wr_en, rd_addr != addr_s1, "line memory read and write hit one entry")
	`PNGU_ASSERT_IMP(a_load_needs_room, in_load, s1_free, "word loaded into busy stage")
	`PNGU_ASSERT_NXT(a_row_start_clears, s1_go && !is_sample, (left_q == 32'd0) && (upper_q == 32'd0) && (asm_q == 24'd0), "row start left history")

endmodule

@@ sv/pngu_argb.sv @@
// ---------------------------------------------------------------------------
// pngu_argb
// palette memory, colour conversion and output register
// ---------------------------------------------------------------------------
`include "png_scanline_unfilter_to_argb_core_assert.svh"

module pngu_argb (
	input  logic            clk,
	input  logic            arst_n,
	input  pngu_pkg::cfg_t  cfg,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  logic [31:0]     px,
	input  logic            pix_row_end,
	input  logic            pal_we,
	input  logic [7:0]      pal_slot,
	input  logic [23:0]     pal_color,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [31:0]     pixel_argb,
	output logic            row_end
);

	logic           s2_valid_q;
	logic [31:0]    px_s2;
	logic           row_end_s2;
	logic [23:0]    pal_rd_s2;
	logic           pal_hit_s2;
	logic [255:0]   pal_vld_q;
	logic           out_valid_q;
	logic [31:0]    argb_q;
	logic           row_end_q;

	logic           out_en;
	logic           s2_go;
	logic           s2_load;
	logic [23:0]    pal_entry;
	logic [31:0]    argb_c;

	logic [23:0]    pal_mem [256];

	// stage handshake
	always_comb begin
		out_en    = !out_valid_q || out_ready;
		s2_go     = s2_valid_q && out_en;
		pix_ready = !s2_valid_q || s2_go;
		s2_load   = pix_valid && pix_ready;
	end

	// colour conversion
	always_comb begin
		pal_entry = pal_hit_s2 ? pal_rd_s2 : 24'd0;
		unique case (cfg.pixel_format)
			pngu_pkg::FMT_RGBA:       argb_c = {px_s2[7:0], px_s2[31:8]};
			pngu_pkg::FMT_RGB:        argb_c = pngu_pkg::ARGB_OPAQUE | {8'd0, px_s2[23:0]};
			pngu_pkg::FMT_INDEXED:    argb_c = cfg.palette_valid ?
				(pngu_pkg::ARGB_OPAQUE | {8'd0, pal_entry}) : pngu_pkg::ARGB_OPAQUE;
			pngu_pkg::FMT_GRAY:       argb_c = pngu_pkg::ARGB_OPAQUE |
				{8'd0, px_s2[7:0], px_s2[7:0], px_s2[7:0]};
			pngu_pkg::FMT_GRAY_ALPHA: argb_c = {px_s2[7:0], px_s2[15:8], px_s2[15:8],
				px_s2[15:8]};
			default:                  argb_c = pngu_pkg::ARGB_OPAQUE;
		endcase
	end

	// palette memory: write on acceptance, read as the pixel enters the stage
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pal_slot] <= pal_color;
		end
		if (s2_load) begin
			pal_rd_s2 <= pal_mem[px[7:0]];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (pal_we) begin
			pal_vld_q[pal_slot] <= 1'b1;
		end
	end

	// stage word
	always_ff @(posedge clk) begin
		if (s2_load) begin
			px_s2      <= px;
			row_end_s2 <= pix_row_end;
			pal_hit_s2 <= pal_vld_q[px[7:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_load) begin
			s2_valid_q <= 1'b1;
		end else if (s2_go) begin
			s2_valid_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (s2_go) begin
			argb_q    <= argb_c;
			row_end_q <= row_end_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= s2_valid_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_argb = argb_q;
	assign row_end    = row_end_q;

	`PNGU_ASSERT_NXT(a_pal_write_marks, pal_we, pal_vld_q[$past(pal_slot)], "palette entry not marked after write")
	`PNGU_ASSERT_NXT(a_s2_holds, s2_valid_q && !out_en, s2_valid_q && $stable(px_s2), "pixel lost while output stalled")

endmodule

@@ sv/png_scanline_unfilter_to_argb_core.sv @@
// a pixel word leaves through the reconstruction, conversion and output registers
// throughput: one input word per cycle; input stalls only while the output is held and
// both pixel stages behind it are full
// the upper row byte is read at acceptance and the byte before it written back in the
// same cycle, so consecutive bytes of a row never stall each other
// reset: row control, history, configuration and palette valid bits clear at once;
// the line memory is not cleared and needs no clearing pass, palette reads zero until written
// ---------------------------------------------------------------------------
// png_scanline_unfilter_to_argb_core
// png filter reconstruction of an inflated 8-bit stream with argb conversion
// ---------------------------------------------------------------------------
module png_scanline_unfilter_to_argb_core #(
	parameter int MAX_WIDTH = 4096,
	parameter int ROW_BYTES = 16384
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [pngu_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pngu_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                command,
	input  logic [7:0]                          image_byte,
	input  logic                                image_start,
	input  logic [7:0]                          palette_slot,
	input  logic [23:0]                         palette_color,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [31:0]                         pixel_argb,
	output logic                                row_end
);

	localparam int ADDR_W = $clog2(ROW_BYTES);

	pngu_pkg::cfg_t     cfg_q;
	logic               in_fire;
	logic               img_fire;
	logic               pal_we;
	pngu_pkg::smp_t     smp;
	logic [ADDR_W-1:0]  rd_addr;
	logic               s1_free;
	logic               pix_valid;
	logic               pix_ready;
	logic [31:0]        px;
	logic               pix_row_end;

	// acceptance
	always_comb begin
		in_ready = s1_free;
		in_fire  = in_valid && in_ready;
		img_fire = in_fire && (command == pngu_pkg::CMD_STREAM);
		pal_we   = in_fire && (command == pngu_pkg::CMD_PALETTE);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= 13'd1;
			cfg_q.pixel_format  <= pngu_pkg::FMT_GRAY;
			cfg_q.palette_valid <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pngu_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[12:0];
				pngu_pkg::REG_PIXEL_FORMAT:  cfg_q.pixel_format  <= cfg_data[2:0];
				pngu_pkg::REG_PALETTE_VALID: cfg_q.palette_valid <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pngu_row_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.ROW_BYTES (ROW_BYTES)
	) u_row_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.img_fire    (img_fire),
		.image_byte  (image_byte),
		.image_start (image_start),
		.smp         (smp),
		.rd_addr     (rd_addr)
	);

	pngu_recon #(
		.ROW_BYTES (ROW_BYTES)
	) u_recon (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_load     (img_fire),
		.smp         (smp),
		.rd_addr     (rd_addr),
		.s1_free     (s1_free),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.px          (px),
		.pix_row_end (pix_row_end)
	);

	pngu_argb u_argb (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.px          (px),
		.pix_row_end (pix_row_end),
		.pal_we      (pal_we),
		.pal_slot    (palette_slot),
		.pal_color   (palette_color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_argb  (pixel_argb),
		.row_end     (row_end)
	);

endmodule
